FILE: hdl/kpsp_pkg.sv
`timescale 1ns / 1ps

package kpsp_pkg;

   localparam int COL_W      = 3;
   localparam int ROW_W      = 4;
   localparam int DUR_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TICKS = 2'd1;

   localparam logic [DUR_W-1:0] LONG_TICKS_RESET  = 16'd5000;
   localparam logic [DUR_W-1:0] SHORT_TICKS_RESET = 16'd1000;

   // all columns released
   localparam logic [COL_W-1:0] COLS_IDLE = 3'b111;

   typedef enum logic [1:0] {
      MODE_SCAN = 2'd0,
      MODE_SEND = 2'd1,
      MODE_WAIT = 2'd2
   } mode_type;

   typedef struct packed {
      logic [DUR_W-1:0] long_ticks;
      logic [DUR_W-1:0] short_ticks;
   } cfg_type;

   typedef struct packed {
      logic             busy_res;
      logic [7:0]       key_byte;
      logic             byte_valid;
      logic             line_level;
      logic [ROW_W-1:0] row_drive;
   } result_type;

   // key index row*3+col to ASCII
   function automatic logic [7:0] key_code(input logic [3:0] idx);
      logic [7:0] code;
      case (idx)
         4'd0:    code = 8'h31;
         4'd1:    code = 8'h32;
         4'd2:    code = 8'h33;
         4'd3:    code = 8'h34;
         4'd4:    code = 8'h35;
         4'd5:    code = 8'h36;
         4'd6:    code = 8'h37;
         4'd7:    code = 8'h38;
         4'd8:    code = 8'h39;
         4'd9:    code = 8'h2A;
         4'd10:   code = 8'h30;
         4'd11:   code = 8'h23;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

FILE: hdl/keypad_scan_pulse_width_sender.sv
`timescale 1ns / 1ps
// A result beat is registered in the output buffer's main entry, or in its skid entry during a stall.
// Throughput: one beat per cycle while req_tready is high; the scan/send state updates in
// a single pass and a two-entry output buffer drops req_tready only once its skid holds a stalled beat.
// Reset (synchronous, active high): scanning at row 0, counters and key byte
// cleared, long/short durations back to 5000/1000, output buffer empty.
module keypad_scan_pulse_width_sender
   import kpsp_pkg::*;
#(
   parameter int TICK_COUNTER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: [2:0] column_lines, [7:3] zero
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: [3:0] row_drive, [4] line_level, [5] byte_valid,
   //            [13:6] key_byte, [14] busy_res, [15] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DUR_W-1:0]      csr_data
);

   cfg_type    cfg_ff;
   result_type step_result;
   result_type rsp_result;
   logic       step_en;

   // register writes, unknown indexes dropped
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_ticks  <= LONG_TICKS_RESET;
         cfg_ff.short_ticks <= SHORT_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LONG_TICKS:  cfg_ff.long_ticks  <= csr_data;
            CSR_SHORT_TICKS: cfg_ff.short_ticks <= csr_data;
            default: ;
         endcase
      end
   end

   assign step_en = req_tvalid && req_tready;

   kpsp_core #(
      .TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .column_lines (req_tdata[COL_W-1:0]),
      .cfg          (cfg_ff),
      .result       (step_result)
   );

   kpsp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (step_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {1'b0, rsp_result};

endmodule

FILE: hdl/kpsp_core.sv
`timescale 1ns / 1ps

module kpsp_core
   import kpsp_pkg::*;
#(
   parameter int TICK_COUNTER_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [COL_W-1:0] column_lines,
   input  cfg_type          cfg,
   output result_type       result
);

   localparam int TW = TICK_COUNTER_WIDTH;
   localparam int EW = (TW > DUR_W) ? TW : DUR_W;
   localparam logic [EW-1:0] CNT_MAX = EW'({TW{1'b1}});

   mode_type      mode_ff, mode_in;
   logic [1:0]    scan_row_ff, scan_row_in;
   logic [2:0]    bit_index_ff, bit_index_in;
   logic          phase_high_ff, phase_high_in;
   logic [TW-1:0] tick_count_ff, tick_count_in;
   logic [7:0]    shift_byte_ff, shift_byte_in;

   logic          cur_bit;
   logic [DUR_W-1:0] dur_reg;
   logic [EW-1:0] dur_ext;
   logic [TW-1:0] dur;
   logic          phase_done;
   logic          key_hit;
   logic [1:0]    col_sel;
   logic [3:0]    key_idx;

   // current bit, MSB first
   assign cur_bit = shift_byte_ff[~bit_index_ff];

   // phase duration: zero acts as one, saturate to counter range
   always_comb begin
      if (phase_high_ff == cur_bit) begin
         dur_reg = cfg.short_ticks;
      end else begin
         dur_reg = cfg.long_ticks;
      end
      dur_ext = EW'(dur_reg);
      if (dur_ext > CNT_MAX) begin
         dur_ext = CNT_MAX;
      end
      dur = dur_ext[TW-1:0];
      if (dur == '0) begin
         dur = TW'(1);
      end
   end

   assign phase_done = ({1'b0, tick_count_ff} + (TW+1)'(1)) >= {1'b0, dur};

   // first low column wins
   assign key_hit = column_lines != COLS_IDLE;
   always_comb begin
      if (!column_lines[2]) begin
         col_sel = 2'd0;
      end else if (!column_lines[1]) begin
         col_sel = 2'd1;
      end else begin
         col_sel = 2'd2;
      end
   end
   assign key_idx = {1'b0, scan_row_ff, 1'b0} + {2'b00, scan_row_ff} + {2'b00, col_sel};

   // next mode
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_SEND: begin
            if (phase_done && phase_high_ff && (bit_index_ff == 3'd7)) begin
               mode_in = MODE_WAIT;
            end
         end
         MODE_WAIT: begin
            if (!key_hit) begin
               mode_in = MODE_SCAN;
            end
         end
         default: begin
            mode_in = key_hit ? MODE_SEND : MODE_SCAN;
         end
      endcase
   end

   // datapath and result
   always_comb begin
      scan_row_in   = scan_row_ff;
      bit_index_in  = bit_index_ff;
      phase_high_in = phase_high_ff;
      tick_count_in = tick_count_ff;
      shift_byte_in = shift_byte_ff;
      result.row_drive  = ~(ROW_W'(1) << scan_row_ff);
      result.line_level = 1'b1;
      result.byte_valid = 1'b0;
      result.busy_res   = 1'b0;
      case (mode_ff)
         MODE_SEND: begin
            result.busy_res   = 1'b1;
            result.line_level = phase_high_ff;
            if (phase_done) begin
               tick_count_in = '0;
               phase_high_in = !phase_high_ff;
               if (phase_high_ff) begin
                  bit_index_in = bit_index_ff + 3'd1;
                  result.byte_valid = bit_index_ff == 3'd7;
               end
            end else begin
               tick_count_in = tick_count_ff + TW'(1);
            end
         end
         MODE_WAIT: begin
            result.busy_res = 1'b1;
         end
         default: begin
            if (key_hit) begin
               shift_byte_in = key_code(key_idx);
               bit_index_in  = '0;
               phase_high_in = 1'b0;
               tick_count_in = '0;
            end else begin
               scan_row_in = scan_row_ff + 2'd1;
            end
         end
      endcase
      result.key_byte = shift_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SCAN;
         scan_row_ff   <= '0;
         bit_index_ff  <= '0;
         phase_high_ff <= 1'b0;
         tick_count_ff <= '0;
         shift_byte_ff <= '0;
      end else if (step_en) begin
         mode_ff       <= mode_in;
         scan_row_ff   <= scan_row_in;
         bit_index_ff  <= bit_index_in;
         phase_high_ff <= phase_high_in;
         tick_count_ff <= tick_count_in;
         shift_byte_ff <= shift_byte_in;
      end
   end

`ifndef NO_ASSERTIONS
   // bit timing state is parked at zero outside a send
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_SEND) |->
         (tick_count_ff == '0 && bit_index_ff == '0 && !phase_high_ff))
      else $error("bit timing state not clear outside send");

   // byte done only comes out of a send
   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      result.byte_valid |-> (mode_ff == MODE_SEND && phase_high_ff))
      else $error("byte_valid outside the last high phase");

   // finished byte moves to waiting for release
   a_valid_wait: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.byte_valid) |=> (mode_ff == MODE_WAIT))
      else $error("no wait after byte done");
`endif

endmodule

FILE: hdl/kpsp_skid.sv
`timescale 1ns / 1ps

module kpsp_skid
   import kpsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       in_fire;
   logic       out_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_fire  = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // two-entry buffer: main drives the port, skid catches a beat during a stall
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (out_fire) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (in_fire) begin
            main_in = in_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         if (!main_valid_ff) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef NO_ASSERTIONS
   // skid never holds a beat behind an empty main stage
   a_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid full while main empty");

   // a beat taken during a stall lands in the skid
   a_catch: assert property (@(posedge clock) disable iff (reset)
      (in_fire && main_valid_ff && !out_ready) |=> skid_valid_ff)
      else $error("stalled beat not caught");

   // draining the skid refills main
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_fire) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid drain lost a beat");
`endif

endmodule
